@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the calendar clock block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge, quiet during reset
`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, also live while reset is asserted
`define ASSERT_CLK_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/cca_pkg.sv @@
// ----------------------------------------------------------------------------
// cca_pkg
// Types, codes and calendar helpers for the calendar clock advance block.
// ----------------------------------------------------------------------------
package cca_pkg;

   // Request codes
   localparam logic REQ_ADVANCE = 1'b0;
   localparam logic REQ_LOAD    = 1'b1;

   // Month codes, January is zero
   localparam logic [3:0] JANUARY   = 4'd0;
   localparam logic [3:0] FEBRUARY  = 4'd1;
   localparam logic [3:0] MARCH     = 4'd2;
   localparam logic [3:0] APRIL     = 4'd3;
   localparam logic [3:0] MAY       = 4'd4;
   localparam logic [3:0] JUNE      = 4'd5;
   localparam logic [3:0] JULY      = 4'd6;
   localparam logic [3:0] AUGUST    = 4'd7;
   localparam logic [3:0] SEPTEMBER = 4'd8;
   localparam logic [3:0] OCTOBER   = 4'd9;
   localparam logic [3:0] NOVEMBER  = 4'd10;
   localparam logic [3:0] DECEMBER  = 4'd11;

   localparam logic [13:0] YEAR_MAX = 14'd9999;

   // Reciprocal of 25 scaled by 2^17, exact for every 14-bit year
   localparam logic [12:0] RECIP_25  = 13'd5243;
   localparam int          RECIP_SHR = 17;

   typedef struct packed {
      logic        req_type;
      logic [5:0]  delta_seconds;
      logic [13:0] load_year;
      logic [3:0]  load_month;
      logic [4:0]  load_day;
      logic [4:0]  load_hour;
      logic [5:0]  load_minute;
      logic [5:0]  load_second;
   } req_payload_type;

   typedef struct packed {
      logic [13:0] year_out;
      logic [3:0]  month_out;
      logic [4:0]  day_out;
      logic [4:0]  hour_out;
      logic [5:0]  minute_out;
      logic [5:0]  second_out;
   } rsp_payload_type;

   // Gregorian leap rule; divisibility by 100 and 400 split into 4/16 and 25
   function automatic logic is_leap(input logic [13:0] year);
      logic [26:0] prod;
      logic [9:0]  quot;
      logic [14:0] back;
      logic        div25;
      prod  = 27'(year) * 27'(RECIP_25);
      quot  = prod[26:RECIP_SHR];
      back  = 15'({quot, 4'b0000}) + 15'({quot, 3'b000}) + 15'(quot);
      div25 = (back == 15'(year));
      return ((year[1:0] == 2'b00) && !div25) || ((year[3:0] == 4'b0000) && div25);
   endfunction

   // Days in a month; zero for codes past December (no day check there)
   function automatic logic [4:0] month_length(input logic [3:0] month,
                                               input logic       leap);
      logic [4:0] len;
      unique case (month)
         JANUARY, MARCH, MAY, JULY,
         AUGUST, OCTOBER, DECEMBER: len = 5'd31;
         APRIL, JUNE, SEPTEMBER, NOVEMBER: len = 5'd30;
         FEBRUARY: len = leap ? 5'd29 : 5'd28;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

@@ hdl/cca_ifs.sv @@
// ----------------------------------------------------------------------------
// cca_ifs
// Valid/ready channels for requests and responses of the calendar clock.
// ----------------------------------------------------------------------------
interface cca_req_if;
   logic                     valid;
   logic                     ready;
   cca_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface cca_rsp_if;
   logic                     valid;
   logic                     ready;
   cca_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/calendar_clock_advance.sv @@
// ----------------------------------------------------------------------------
// calendar_clock_advance
// Calendar time keeper: advance by up to 63 seconds or load a full time.
// ----------------------------------------------------------------------------
// Each request is accepted, the new time is worked out in a single pass
// of carry logic (second, minute, hour, day, month, year) from the time
// registers, and the result lands in the response register on the same
// edge that updates the time. A request is taken in every cycle in which
// the response register is empty or being drained, so throughput is one
// request per clock. The leap-year test uses one small constant multiply
// on the current year. After reset the time is 0000-January-01 00:00:00.

`include "assert_macros.svh"

module calendar_clock_advance (
   input logic      clock,
   input logic      reset,
   cca_req_if.sink  req_port,
   cca_rsp_if.source rsp_port
);

   cca_pkg::rsp_payload_type time_ff, time_in;
   cca_pkg::rsp_payload_type rsp_data_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     req_fire;

   logic [6:0]  sec_sum;
   logic [5:0]  sec_new;
   logic [1:0]  sec_carry;
   logic [6:0]  min_sum;
   logic [5:0]  min_new;
   logic        min_carry;
   logic [5:0]  hour_sum;
   logic [4:0]  hour_new;
   logic        hour_carry;
   logic [5:0]  day_sum;
   logic [4:0]  month_len;
   logic [4:0]  month_sum;
   logic [14:0] year_sum;
   cca_pkg::rsp_payload_type adv_time;

   // Take a request whenever the response slot is free or draining
   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign req_fire       = req_port.valid && req_port.ready;

   // Seconds: sum reaches at most 126, so carry is 0, 1 or 2
   always_comb begin
      sec_sum = {1'b0, time_ff.second_out} + {1'b0, req_port.payload.delta_seconds};
      if (sec_sum >= 7'd120) begin
         sec_carry = 2'd2;
         sec_new   = 6'(sec_sum - 7'd120);
      end else if (sec_sum >= 7'd60) begin
         sec_carry = 2'd1;
         sec_new   = 6'(sec_sum - 7'd60);
      end else begin
         sec_carry = 2'd0;
         sec_new   = sec_sum[5:0];
      end
   end

   // Minutes and hours: each carries at most once
   always_comb begin
      min_sum   = {1'b0, time_ff.minute_out} + 7'(sec_carry);
      min_carry = (min_sum >= 7'd60);
      min_new   = min_carry ? 6'(min_sum - 7'd60) : min_sum[5:0];

      hour_sum   = {1'b0, time_ff.hour_out} + 6'(min_carry);
      hour_carry = (hour_sum > 6'd23);
      hour_new   = hour_carry ? 5'(hour_sum - 6'd24) : hour_sum[4:0];
   end

   // Days, month rollover and year wrap
   always_comb begin
      day_sum   = {1'b0, time_ff.day_out} + 6'(hour_carry);
      month_len = cca_pkg::month_length(time_ff.month_out,
                                        cca_pkg::is_leap(time_ff.year_out));
      month_sum = {1'b0, time_ff.month_out};
      if ((month_len != 5'd0) && (day_sum > {1'b0, month_len})) begin
         month_sum = month_sum + 5'd1;
         day_sum   = 6'd1;
      end
      year_sum = {1'b0, time_ff.year_out};
      if (month_sum > 5'(cca_pkg::DECEMBER)) begin
         year_sum  = year_sum + 15'd1;
         month_sum = 5'(cca_pkg::JANUARY);
      end
      if (year_sum > {1'b0, cca_pkg::YEAR_MAX}) begin
         year_sum = 15'd0;
      end

      adv_time.year_out   = year_sum[13:0];
      adv_time.month_out  = month_sum[3:0];
      adv_time.day_out    = day_sum[4:0];
      adv_time.hour_out   = hour_new;
      adv_time.minute_out = min_new;
      adv_time.second_out = sec_new;
   end

   // Select load or advance for the next time
   always_comb begin
      time_in = time_ff;
      if (req_fire) begin
         if (req_port.payload.req_type == cca_pkg::REQ_LOAD) begin
            time_in.year_out   = req_port.payload.load_year;
            time_in.month_out  = req_port.payload.load_month;
            time_in.day_out    = req_port.payload.load_day;
            time_in.hour_out   = req_port.payload.load_hour;
            time_in.minute_out = req_port.payload.load_minute;
            time_in.second_out = req_port.payload.load_second;
         end else begin
            time_in = adv_time;
         end
      end
   end

   // Response slot fills on accept, drains on handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Hold time registers; reset to January 1st, year zero
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff.year_out   <= '0;
         time_ff.month_out  <= cca_pkg::JANUARY;
         time_ff.day_out    <= 5'd1;
         time_ff.hour_out   <= '0;
         time_ff.minute_out <= '0;
         time_ff.second_out <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= time_in;
      end
   end

   assign rsp_port.valid   = rsp_valid_ff;
   assign rsp_port.payload = rsp_data_ff;

   // Checks
   `ASSERT_CLK(a_fire_fills_rsp, clock, reset,
      req_fire |=> rsp_valid_ff,
      "accepted request produced no response")
   `ASSERT_CLK(a_rsp_matches_time, clock, reset,
      rsp_valid_ff |-> (rsp_data_ff == time_ff),
      "pending response differs from held time")
   `ASSERT_CLK(a_year_moves_on_roll, clock, reset,
      (req_fire && (req_port.payload.req_type == cca_pkg::REQ_ADVANCE)) |=>
         ((time_ff.year_out == $past(time_ff.year_out)) ||
          (time_ff.month_out == cca_pkg::JANUARY) || (time_ff.year_out == 14'd0)),
      "year changed without a year rollover")
   `ASSERT_CLK(a_idle_holds_time, clock, reset,
      !req_fire |=> (time_ff == $past(time_ff)),
      "time changed without a request")

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the calendar clock advance block: a directed table
// of loads and advances walks the corner dates (year wrap, leap and common
// February, month ends, out-of-range loads), then random load/advance runs
// mostly around month and year boundaries. Every response is checked against its
// directed row or an in-bench calendar predictor; both channels idle at random.
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned RANDOM_REQUESTS = 1525;
   localparam int unsigned CYCLE_LIMIT     = 200000;
   localparam int unsigned DRAIN_CYCLES    = 4;

   typedef struct {
      cca_pkg::req_payload_type rq;
      bit                       typed;
      cca_pkg::rsp_payload_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cca_req_if req_chan ();
   cca_rsp_if rsp_chan ();

   cca_pkg::rsp_payload_type expected_times[$];
   cca_pkg::rsp_payload_type calendar_now;
   stim_row_type             directed_rows[$];

   bit          calm = 1'b0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned checked_count = 0;
   int unsigned load_count = 0;
   int unsigned advance_count = 0;
   int unsigned year_turns = 0;
   int unsigned month_turns = 0;

   calendar_clock_advance i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_chan.sink),
      .rsp_port (rsp_chan.source)
   );

   // 20-unit clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending", cycle_count,
                  expected_times.size());
         $display("tb: errors");
         $finish;
      end
   end

   task automatic note_error(input string msg);
      error_count++;
      $display("mismatch @%0d: %s", cycle_count, msg);
   endtask

   // Days in a month; zero past December, where no day check applies
   function automatic int unsigned days_in_month(input int unsigned mon,
                                                 input int unsigned yr);
      bit leap;
      leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
      case (mon)
         cca_pkg::JANUARY, cca_pkg::MARCH, cca_pkg::MAY, cca_pkg::JULY,
         cca_pkg::AUGUST, cca_pkg::OCTOBER, cca_pkg::DECEMBER: return 31;
         cca_pkg::APRIL, cca_pkg::JUNE, cca_pkg::SEPTEMBER,
         cca_pkg::NOVEMBER: return 30;
         cca_pkg::FEBRUARY: return leap ? 29 : 28;
         default: return 0;
      endcase
   endfunction

   // Calendar time after one request
   function automatic cca_pkg::rsp_payload_type next_time(
         input cca_pkg::rsp_payload_type now,
         input cca_pkg::req_payload_type rq);
      int unsigned              sec, mins, hrs, day, mon, yr, lim;
      cca_pkg::rsp_payload_type nxt;
      if (rq.req_type == cca_pkg::REQ_LOAD) begin
         nxt.year_out   = rq.load_year;
         nxt.month_out  = rq.load_month;
         nxt.day_out    = rq.load_day;
         nxt.hour_out   = rq.load_hour;
         nxt.minute_out = rq.load_minute;
         nxt.second_out = rq.load_second;
         return nxt;
      end
      sec  = now.second_out;
      mins = now.minute_out;
      hrs  = now.hour_out;
      day  = now.day_out;
      mon  = now.month_out;
      yr   = now.year_out;
      sec  = sec + rq.delta_seconds;
      // carry seconds, minutes and hours by division
      mins = mins + sec / 60;
      sec  = sec % 60;
      hrs  = hrs + mins / 60;
      mins = mins % 60;
      day  = day + hrs / 24;
      hrs  = hrs % 24;
      lim  = days_in_month(mon, yr);
      if (lim != 0 && day > lim) begin
         mon = mon + 1;
         day = 1;
      end
      if (mon > cca_pkg::DECEMBER) begin
         yr  = yr + 1;
         mon = cca_pkg::JANUARY;
      end
      if (yr > cca_pkg::YEAR_MAX) yr = 0;
      nxt.year_out   = 14'(yr);
      nxt.month_out  = 4'(mon);
      nxt.day_out    = 5'(day);
      nxt.hour_out   = 5'(hrs);
      nxt.minute_out = 6'(mins);
      nxt.second_out = 6'(sec);
      return nxt;
   endfunction

   function automatic cca_pkg::req_payload_type load_req(
         input int unsigned yr, mon, day,
         input int unsigned hrs, mins, sec);
      cca_pkg::req_payload_type rq;
      rq             = '0;
      rq.req_type    = cca_pkg::REQ_LOAD;
      rq.load_year   = 14'(yr);
      rq.load_month  = 4'(mon);
      rq.load_day    = 5'(day);
      rq.load_hour   = 5'(hrs);
      rq.load_minute = 6'(mins);
      rq.load_second = 6'(sec);
      return rq;
   endfunction

   function automatic cca_pkg::req_payload_type advance_req(input int unsigned delta);
      cca_pkg::req_payload_type rq;
      rq               = '0;
      rq.req_type      = cca_pkg::REQ_ADVANCE;
      rq.delta_seconds = 6'(delta);
      // junk in the load fields must be ignored on an advance
      rq.load_year     = 14'($urandom);
      rq.load_month    = 4'($urandom);
      rq.load_day      = 5'($urandom);
      return rq;
   endfunction

   function automatic cca_pkg::rsp_payload_type clock_time(
         input int unsigned yr, mon, day,
         input int unsigned hrs, mins, sec);
      cca_pkg::rsp_payload_type t;
      t.year_out   = 14'(yr);
      t.month_out  = 4'(mon);
      t.day_out    = 5'(day);
      t.hour_out   = 5'(hrs);
      t.minute_out = 6'(mins);
      t.second_out = 6'(sec);
      return t;
   endfunction

   function automatic void add_row(input cca_pkg::req_payload_type rq, input bit typed,
                                   input cca_pkg::rsp_payload_type want);
      stim_row_type row;
      row.rq    = rq;
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endfunction

   // Load just before a month or year boundary, always in range
   function automatic cca_pkg::req_payload_type boundary_load();
      int unsigned yr, mon, lim;
      case ($urandom_range(0, 11))
         0:       yr = 0;
         1:       yr = 4;
         2:       yr = 100;
         3:       yr = 400;
         4:       yr = 1900;
         5:       yr = 2000;
         6:       yr = 2023;
         7:       yr = 2024;
         8:       yr = 9996;
         9:       yr = cca_pkg::YEAR_MAX;
         default: yr = $urandom_range(0, cca_pkg::YEAR_MAX);
      endcase
      mon = ($urandom_range(0, 3) == 0) ? cca_pkg::DECEMBER : $urandom_range(0, 11);
      lim = days_in_month(mon, yr);
      return load_req(yr, mon, lim - $urandom_range(0, 1),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 23) : 23,
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 59) : 59,
                      59 - $urandom_range(0, 20));
   endfunction

   // Drive one request and record its expected response once accepted
   task automatic drive_request(input cca_pkg::req_payload_type rq, input bit typed,
                                input cca_pkg::rsp_payload_type want);
      int unsigned              gap;
      cca_pkg::rsp_payload_type predicted;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= rq;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predicted = next_time(calendar_now, rq);
      if (rq.req_type == cca_pkg::REQ_LOAD) begin
         load_count++;
      end else begin
         advance_count++;
         if (predicted.year_out != calendar_now.year_out) year_turns++;
         else if (predicted.month_out != calendar_now.month_out) month_turns++;
      end
      calendar_now = predicted;
      expected_times.push_back(typed ? want : predicted);
   endtask

   // Check each response against the oldest expectation
   always @(posedge clock) begin
      cca_pkg::rsp_payload_type got, want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got = rsp_chan.payload;
         if (expected_times.size() == 0) begin
            note_error($sformatf("unexpected response %p", got));
         end else begin
            want = expected_times.pop_front();
            checked_count++;
            if (got.year_out !== want.year_out)
               note_error($sformatf("year %0d, want %0d", got.year_out, want.year_out));
            if (got.month_out !== want.month_out)
               note_error($sformatf("month %0d, want %0d", got.month_out, want.month_out));
            if (got.day_out !== want.day_out)
               note_error($sformatf("day %0d, want %0d", got.day_out, want.day_out));
            if (got.hour_out !== want.hour_out)
               note_error($sformatf("hour %0d, want %0d", got.hour_out, want.hour_out));
            if (got.minute_out !== want.minute_out)
               note_error($sformatf("minute %0d, want %0d", got.minute_out,
                                    want.minute_out));
            if (got.second_out !== want.second_out)
               note_error($sformatf("second %0d, want %0d", got.second_out,
                                    want.second_out));
         end
      end
   end

   // Response side: a random stall before each response, none in calm stretches
   initial begin
      int unsigned stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 4);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid === 1'b1 && !reset));
      end
   end

   // Request side
   initial begin
      int unsigned              sent, runs;
      cca_pkg::rsp_payload_type none;
      none = '0;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      calendar_now = clock_time(0, cca_pkg::JANUARY, 1, 0, 0, 0);

      // reset value, second carry, year wrap
      add_row(advance_req(0), 1, clock_time(0, cca_pkg::JANUARY, 1, 0, 0, 0));
      add_row(advance_req(59), 1, clock_time(0, cca_pkg::JANUARY, 1, 0, 0, 59));
      add_row(advance_req(1), 1, clock_time(0, cca_pkg::JANUARY, 1, 0, 1, 0));
      add_row(load_req(cca_pkg::YEAR_MAX, cca_pkg::DECEMBER, 31, 23, 59, 59), 1,
              clock_time(cca_pkg::YEAR_MAX, cca_pkg::DECEMBER, 31, 23, 59, 59));
      add_row(advance_req(1), 1, clock_time(0, cca_pkg::JANUARY, 1, 0, 0, 0));
      // century year that is not leap
      add_row(load_req(1900, cca_pkg::FEBRUARY, 28, 23, 59, 59), 1,
              clock_time(1900, cca_pkg::FEBRUARY, 28, 23, 59, 59));
      add_row(advance_req(1), 1, clock_time(1900, cca_pkg::MARCH, 1, 0, 0, 0));
      // leap by the 400 rule, then a plain leap year
      add_row(load_req(2000, cca_pkg::FEBRUARY, 28, 23, 59, 30), 0, none);
      add_row(advance_req(30), 0, none);
      add_row(load_req(2024, cca_pkg::FEBRUARY, 29, 23, 59, 59), 0, none);
      add_row(advance_req(1), 0, none);
      add_row(load_req(2023, cca_pkg::APRIL, 30, 23, 59, 58), 0, none);
      add_row(advance_req(2), 0, none);
      // every load field at its all-ones value, then the widest delta
      add_row(load_req(16383, 15, 31, 31, 63, 63), 1,
              clock_time(16383, 15, 31, 31, 63, 63));
      add_row(advance_req(63), 0, none);
      // month code past December: year steps, day kept
      add_row(load_req(0, 13, 5, 0, 0, 0), 0, none);
      add_row(advance_req(0), 1, clock_time(1, cca_pkg::JANUARY, 5, 0, 0, 0));
      // day beyond month length with no carry
      add_row(load_req(5, cca_pkg::APRIL, 31, 0, 0, 0), 0, none);
      add_row(advance_req(0), 1, clock_time(5, cca_pkg::MAY, 1, 0, 0, 0));
      add_row(load_req(0, cca_pkg::JANUARY, 0, 0, 0, 0), 1,
              clock_time(0, cca_pkg::JANUARY, 0, 0, 0, 0));
      add_row(advance_req(63), 0, none);
      add_row(load_req(100, cca_pkg::FEBRUARY, 28, 23, 59, 59), 0, none);
      add_row(advance_req(1), 0, none);
      add_row(load_req(400, cca_pkg::FEBRUARY, 28, 23, 59, 59), 0, none);
      add_row(advance_req(1), 0, none);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         drive_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);

      // hold off until the directed part has fully drained
      req_chan.valid <= 1'b0;
      while (expected_times.size() != 0) @(posedge clock);

      // random runs: mostly a load near a boundary followed by a few advances
      sent = 0;
      runs = 0;
      while (sent < RANDOM_REQUESTS) begin
         calm = ($urandom_range(0, 5) == 0);
         case ($urandom_range(0, 9))
            0: begin
               drive_request(load_req($urandom, $urandom, $urandom,
                                      $urandom, $urandom, $urandom), 0, none);
               drive_request(advance_req($urandom_range(0, 63)), 0, none);
               sent += 2;
            end
            1: begin
               drive_request(advance_req($urandom_range(0, 63)), 0, none);
               sent += 1;
            end
            default: begin
               drive_request(boundary_load(), 0, none);
               sent += 1;
               repeat ($urandom_range(1, 8)) begin
                  drive_request(advance_req(($urandom_range(0, 9) == 0) ?
                                            $urandom_range(60, 63) :
                                            $urandom_range(0, 59)), 0, none);
                  sent += 1;
               end
            end
         endcase
         runs++;
         // drain once mid-run
         if (runs == 100) begin
            req_chan.valid <= 1'b0;
            while (expected_times.size() != 0) @(posedge clock);
         end
      end
      calm = 1'b0;
      req_chan.valid <= 1'b0;

      while (expected_times.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d responses checked, %0d loads, %0d advances",
               checked_count, load_count, advance_count);
      $display("summary: %0d year turnovers and %0d month rollovers crossed",
               year_turns, month_turns);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/cca_pkg.sv
hdl/cca_ifs.sv
hdl/calendar_clock_advance.sv
dv/tb.sv
